/* src/adc_ar_pkg.sv */
`timescale 1ns / 1ps
package adc_ar_pkg;

  localparam int CODE_W = 12;
  localparam int CONF_W = 8;
  localparam int PCT_W  = 7;
  localparam int CFG_W  = 12;
  localparam int IDX_W  = 3;

  localparam int MAX_BLOCK_LEN_DEF        = 65536;
  localparam int OVER_CONFIRM_BLOCKS_DEF  = 1;
  localparam int UNDER_CONFIRM_BLOCKS_DEF = 1;

  localparam logic [CODE_W-1:0] CODE_MIN    = 12'd0;
  localparam logic [CODE_W-1:0] CODE_MAX    = 12'hFFF;
  localparam logic [CODE_W-1:0] MIDSCALE    = 12'd2048;
  localparam logic [CONF_W-1:0] CONFIRM_MAX = 8'hFF;
  localparam logic [PCT_W-1:0]  PCT_SCALE   = 7'd100;

  localparam logic [1:0] RANGE_0V3     = 2'd0;
  localparam logic [1:0] RANGE_3V3     = 2'd1;
  localparam logic [1:0] RANGE_10V     = 2'd2;
  localparam logic [1:0] RANGE_INVALID = 2'd3;

  localparam logic [IDX_W-1:0] REG_AUTO_ENABLE   = 3'd0;
  localparam logic [IDX_W-1:0] REG_MANUAL_RANGE  = 3'd1;
  localparam logic [IDX_W-1:0] REG_RAIL_LOW      = 3'd2;
  localparam logic [IDX_W-1:0] REG_RAIL_HIGH     = 3'd3;
  localparam logic [IDX_W-1:0] REG_RAIL_PERCENT  = 3'd4;
  localparam logic [IDX_W-1:0] REG_DOWN_FROM_TOP = 3'd5;
  localparam logic [IDX_W-1:0] REG_DOWN_FROM_MID = 3'd6;

  typedef struct packed {
    logic [31:0] sample_word;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic              switched;
    logic [1:0]        range_now;
    logic [CODE_W-1:0] peak_dist;
    logic              overrange_seen;
  } out_item_t;

  typedef struct packed {
    logic              auto_enable;
    logic [1:0]        manual_range;
    logic [CODE_W-1:0] rail_low_code;
    logic [CODE_W-1:0] rail_high_code;
    logic [PCT_W-1:0]  rail_hit_percent;
    logic [CODE_W-1:0] down_peak_from_top;
    logic [CODE_W-1:0] down_peak_from_mid;
  } cfg_t;

  typedef struct packed {
    logic       wr;
    logic       clr_confirm;
    logic       apply;
    logic [1:0] apply_range;
  } rng_ctl_t;

endpackage

/* src/adc_block_autorange_control_unit.sv */
`timescale 1ns / 1ps
// ADC auto-range controller. Takes one packed ADC word per cycle (code in bits 27:16)
// while in_ready is high; non-last beats flow even while a result waits at the
// output. A block closed by last gives one result: its last beat is taken into the
// input register, then the min/max/count accumulator, which also snapshots the closed
// block, then the decision logic loads the output register.
// The snapshot register holds one closed block, so a last beat stalls only when both
// the snapshot and the output register are full and out_ready is low. Config writes
// apply at once; write only while no block result is pending.
module adc_block_autorange_control_unit #(
  parameter int MAX_BLOCK_LEN        = adc_ar_pkg::MAX_BLOCK_LEN_DEF,
  parameter int OVER_CONFIRM_BLOCKS  = adc_ar_pkg::OVER_CONFIRM_BLOCKS_DEF,
  parameter int UNDER_CONFIRM_BLOCKS = adc_ar_pkg::UNDER_CONFIRM_BLOCKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  adc_ar_pkg::in_item_t           in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output adc_ar_pkg::out_item_t          out_data,
  input  logic                           cfg_we,
  input  logic [adc_ar_pkg::IDX_W-1:0]   cfg_index,
  input  logic [adc_ar_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_BLOCK_LEN + 1);

  adc_ar_pkg::cfg_t      cfg_r, cfg_nxt;
  adc_ar_pkg::rng_ctl_t  rng_ctl;
  logic                  snap_valid, snap_take;
  logic [adc_ar_pkg::CODE_W-1:0] snap_min, snap_max;
  logic [CNT_W-1:0]      snap_cnt, snap_hit;

  always_comb begin
    cfg_nxt             = cfg_r;
    rng_ctl.wr          = 1'b0;
    rng_ctl.clr_confirm = 1'b0;
    rng_ctl.apply       = 1'b0;
    rng_ctl.apply_range = cfg_r.manual_range;
    if (cfg_we) begin
      case (cfg_index)
        adc_ar_pkg::REG_AUTO_ENABLE: begin
          cfg_nxt.auto_enable = cfg_wdata[0];
          rng_ctl.wr          = 1'b1;
          rng_ctl.clr_confirm = 1'b1;
          rng_ctl.apply       = !cfg_wdata[0];
        end
        adc_ar_pkg::REG_MANUAL_RANGE: begin
          cfg_nxt.manual_range = cfg_wdata[1:0];
          rng_ctl.wr           = 1'b1;
          rng_ctl.apply        = !cfg_r.auto_enable;
          rng_ctl.apply_range  = cfg_wdata[1:0];
        end
        adc_ar_pkg::REG_RAIL_LOW:      cfg_nxt.rail_low_code = cfg_wdata;
        adc_ar_pkg::REG_RAIL_HIGH:     cfg_nxt.rail_high_code = cfg_wdata;
        adc_ar_pkg::REG_RAIL_PERCENT:  cfg_nxt.rail_hit_percent = cfg_wdata[adc_ar_pkg::PCT_W-1:0];
        adc_ar_pkg::REG_DOWN_FROM_TOP: cfg_nxt.down_peak_from_top = cfg_wdata;
        adc_ar_pkg::REG_DOWN_FROM_MID: cfg_nxt.down_peak_from_mid = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.auto_enable        <= 1'b1;
      cfg_r.manual_range       <= adc_ar_pkg::RANGE_10V;
      cfg_r.rail_low_code      <= 12'd128;
      cfg_r.rail_high_code     <= 12'd3967;
      cfg_r.rail_hit_percent   <= 7'd2;
      cfg_r.down_peak_from_top <= 12'd650;
      cfg_r.down_peak_from_mid <= 12'd300;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  adc_ar_stats #(
    .MAX_BLOCK_LEN (MAX_BLOCK_LEN),
    .CNT_W         (CNT_W)
  ) u_stats (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .cfg        (cfg_r),
    .snap_valid (snap_valid),
    .snap_take  (snap_take),
    .snap_min   (snap_min),
    .snap_max   (snap_max),
    .snap_cnt   (snap_cnt),
    .snap_hit   (snap_hit)
  );

  adc_ar_decide #(
    .CNT_W                (CNT_W),
    .OVER_CONFIRM_BLOCKS  (OVER_CONFIRM_BLOCKS),
    .UNDER_CONFIRM_BLOCKS (UNDER_CONFIRM_BLOCKS)
  ) u_decide (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .rng_ctl    (rng_ctl),
    .snap_valid (snap_valid),
    .snap_take  (snap_take),
    .snap_min   (snap_min),
    .snap_max   (snap_max),
    .snap_cnt   (snap_cnt),
    .snap_hit   (snap_hit),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

/* src/adc_ar_stats.sv */
`timescale 1ns / 1ps
module adc_ar_stats #(
  parameter int MAX_BLOCK_LEN = adc_ar_pkg::MAX_BLOCK_LEN_DEF,
  parameter int CNT_W         = $clog2(MAX_BLOCK_LEN + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  adc_ar_pkg::in_item_t           in_data,
  input  adc_ar_pkg::cfg_t               cfg,
  output logic                           snap_valid,
  input  logic                           snap_take,
  output logic [adc_ar_pkg::CODE_W-1:0]  snap_min,
  output logic [adc_ar_pkg::CODE_W-1:0]  snap_max,
  output logic [CNT_W-1:0]               snap_cnt,
  output logic [CNT_W-1:0]               snap_hit
);

  localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_BLOCK_LEN);

  adc_ar_pkg::in_item_t            in_r;
  logic                            in_v_r, in_v_nxt;
  logic [adc_ar_pkg::CODE_W-1:0]   min_r, min_nxt, max_r, max_nxt;
  logic [CNT_W-1:0]                cnt_r, cnt_nxt, hit_r, hit_nxt;
  logic [adc_ar_pkg::CODE_W-1:0]   smin_r, smax_r;
  logic [CNT_W-1:0]                scnt_r, shit_r;
  logic                            snap_v_r, snap_v_nxt;
  logic [adc_ar_pkg::CODE_W-1:0]   code;
  logic [adc_ar_pkg::CODE_W-1:0]   upd_min, upd_max;
  logic [CNT_W-1:0]                upd_cnt, upd_hit;
  logic                            rail, in_move, step, close;

  assign code    = in_r.sample_word[27:16];
  assign rail    = (code <= cfg.rail_low_code) || (code >= cfg.rail_high_code);
  assign upd_min = (code < min_r) ? code : min_r;
  assign upd_max = (code > max_r) ? code : max_r;
  assign upd_cnt = (cnt_r < CNT_SAT) ? cnt_r + 1'b1 : cnt_r;
  assign upd_hit = (rail && hit_r < CNT_SAT) ? hit_r + 1'b1 : hit_r;

  assign in_move  = !in_r.last || !snap_v_r || snap_take;
  assign step     = in_v_r && in_move;
  assign close    = step && in_r.last;
  assign in_ready = !in_v_r || in_move;

  always_comb begin
    in_v_nxt = in_ready ? in_valid : in_v_r;
    min_nxt  = min_r;
    max_nxt  = max_r;
    cnt_nxt  = cnt_r;
    hit_nxt  = hit_r;
    if (close) begin
      min_nxt = adc_ar_pkg::CODE_MAX;
      max_nxt = adc_ar_pkg::CODE_MIN;
      cnt_nxt = '0;
      hit_nxt = '0;
    end else if (step) begin
      min_nxt = upd_min;
      max_nxt = upd_max;
      cnt_nxt = upd_cnt;
      hit_nxt = upd_hit;
    end
    snap_v_nxt = close ? 1'b1 : (snap_take ? 1'b0 : snap_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r   <= 1'b0;
      snap_v_r <= 1'b0;
      min_r    <= adc_ar_pkg::CODE_MAX;
      max_r    <= adc_ar_pkg::CODE_MIN;
      cnt_r    <= '0;
      hit_r    <= '0;
    end else begin
      in_v_r   <= in_v_nxt;
      snap_v_r <= snap_v_nxt;
      min_r    <= min_nxt;
      max_r    <= max_nxt;
      cnt_r    <= cnt_nxt;
      hit_r    <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      in_r <= in_data;
    end
    if (close) begin
      smin_r <= upd_min;
      smax_r <= upd_max;
      scnt_r <= upd_cnt;
      shit_r <= upd_hit;
    end
  end

  assign snap_valid = snap_v_r;
  assign snap_min   = smin_r;
  assign snap_max   = smax_r;
  assign snap_cnt   = scnt_r;
  assign snap_hit   = shit_r;

endmodule

/* src/adc_ar_decide.sv */
`timescale 1ns / 1ps
module adc_ar_decide #(
  parameter int CNT_W                = 17,
  parameter int OVER_CONFIRM_BLOCKS  = adc_ar_pkg::OVER_CONFIRM_BLOCKS_DEF,
  parameter int UNDER_CONFIRM_BLOCKS = adc_ar_pkg::UNDER_CONFIRM_BLOCKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  adc_ar_pkg::cfg_t               cfg,
  input  adc_ar_pkg::rng_ctl_t           rng_ctl,
  input  logic                           snap_valid,
  output logic                           snap_take,
  input  logic [adc_ar_pkg::CODE_W-1:0]  snap_min,
  input  logic [adc_ar_pkg::CODE_W-1:0]  snap_max,
  input  logic [CNT_W-1:0]               snap_cnt,
  input  logic [CNT_W-1:0]               snap_hit,
  output logic                           out_valid,
  input  logic                           out_ready,
  output adc_ar_pkg::out_item_t          out_data
);

  localparam int PROD_W = CNT_W + adc_ar_pkg::PCT_W;
  localparam logic [adc_ar_pkg::CONF_W-1:0] OVER_N  = adc_ar_pkg::CONF_W'(OVER_CONFIRM_BLOCKS);
  localparam logic [adc_ar_pkg::CONF_W-1:0] UNDER_N = adc_ar_pkg::CONF_W'(UNDER_CONFIRM_BLOCKS);

  logic [1:0]                      range_r, range_nxt;
  logic [adc_ar_pkg::CONF_W-1:0]   oc_r, oc_nxt, uc_r, uc_nxt, oc_inc, uc_inc;
  logic                            out_v_r, out_v_nxt;
  adc_ar_pkg::out_item_t           out_r, res;
  logic [adc_ar_pkg::CODE_W-1:0]   below_mid, above_mid, peak;
  logic [PROD_W-1:0]               lim_x, hit_x;
  logic                            over, under, fire, sw;

  assign below_mid = (snap_min < adc_ar_pkg::MIDSCALE) ? adc_ar_pkg::MIDSCALE - snap_min : '0;
  assign above_mid = (snap_max > adc_ar_pkg::MIDSCALE) ? snap_max - adc_ar_pkg::MIDSCALE : '0;
  assign peak      = (below_mid > above_mid) ? below_mid : above_mid;

  // hits >= ceil(cnt*pct/100), floor of one
  assign lim_x = PROD_W'(snap_cnt) * PROD_W'(cfg.rail_hit_percent);
  assign hit_x = PROD_W'(snap_hit) * PROD_W'(adc_ar_pkg::PCT_SCALE);
  assign over  = (hit_x >= lim_x) && (snap_hit != '0);

  assign under = (range_r == adc_ar_pkg::RANGE_10V && peak < cfg.down_peak_from_top) ||
                 (range_r == adc_ar_pkg::RANGE_3V3 && peak < cfg.down_peak_from_mid);

  assign oc_inc = (oc_r < adc_ar_pkg::CONFIRM_MAX) ? oc_r + 1'b1 : oc_r;
  assign uc_inc = (uc_r < adc_ar_pkg::CONFIRM_MAX) ? uc_r + 1'b1 : uc_r;

  assign snap_take = !out_v_r || out_ready;
  assign fire      = snap_valid && snap_take;

  always_comb begin
    range_nxt = range_r;
    oc_nxt    = oc_r;
    uc_nxt    = uc_r;
    sw        = 1'b0;
    if (rng_ctl.wr) begin
      if (rng_ctl.clr_confirm) begin
        oc_nxt = '0;
        uc_nxt = '0;
      end
      if (rng_ctl.apply && rng_ctl.apply_range != adc_ar_pkg::RANGE_INVALID &&
          rng_ctl.apply_range != range_r) begin
        range_nxt = rng_ctl.apply_range;
        oc_nxt    = '0;
        uc_nxt    = '0;
      end
    end else if (fire && cfg.auto_enable) begin
      if (over) begin
        uc_nxt = '0;
        oc_nxt = oc_inc;
        if (oc_inc >= OVER_N && range_r < adc_ar_pkg::RANGE_10V) begin
          range_nxt = range_r + 1'b1;
          oc_nxt    = '0;
          uc_nxt    = '0;
          sw        = 1'b1;
        end
      end else begin
        oc_nxt = '0;
        if (under) begin
          uc_nxt = uc_inc;
          if (uc_inc >= UNDER_N) begin
            range_nxt = range_r - 1'b1;
            oc_nxt    = '0;
            uc_nxt    = '0;
            sw        = 1'b1;
          end
        end else begin
          uc_nxt = '0;
        end
      end
    end
    res.switched       = sw;
    res.range_now      = range_nxt;
    res.peak_dist      = peak;
    res.overrange_seen = over;
    out_v_nxt          = fire ? 1'b1 : (out_ready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_r <= adc_ar_pkg::RANGE_10V;
      oc_r    <= '0;
      uc_r    <= '0;
      out_v_r <= 1'b0;
    end else begin
      range_r <= range_nxt;
      oc_r    <= oc_nxt;
      uc_r    <= uc_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_range_legal: assert property (@(posedge clk) disable iff (!rst_n)
    range_r != adc_ar_pkg::RANGE_INVALID)
    else $error("active range holds invalid code");

  a_switch_moves: assert property (@(posedge clk) disable iff (!rst_n)
    fire && sw |=> range_r != $past(range_r))
    else $error("switch reported without range change");

  a_switch_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && sw |=> oc_r == '0 && uc_r == '0)
    else $error("confirm counters not cleared on range change");

  a_manual_holds: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !cfg.auto_enable && !rng_ctl.wr |=> $stable(range_r))
    else $error("range moved in manual mode");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_r.range_now == range_r)
    else $error("reported range differs from active range");
`endif

endmodule

/* sim/tb_adc_block_autorange_control_unit.sv */
`timescale 1ns / 1ps
module tb_adc_block_autorange_control_unit;
  import adc_ar_pkg::*;

  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int RANDOM_BEATS = 1000;
  localparam int RAIL_BLOCK   = 20;

  typedef enum {TONE_QUIET, TONE_LOUD, TONE_ANY, TONE_BORDER} tone_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  adc_block_autorange_control_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // predictor state
  cfg_t regs;
  logic [CODE_W-1:0] acc_min, acc_max;
  logic [16:0] acc_count, acc_rails;
  logic [1:0] cur_range;
  logic [CONF_W-1:0] over_cnt, under_cnt;

  in_item_t beat_q[$];
  out_item_t report_q[$];
  int n_errors = 0;
  int n_pushed = 0;
  int gap_left = 0;
  int stall_left = 0;
  bit no_gaps = 1'b0;
  out_item_t want;

  task automatic flag_mismatch(string what);
    $display("ERROR @%0t: %s", $realtime, what);
    n_errors++;
  endtask

  function automatic void clear_stats();
    acc_min = CODE_MAX;
    acc_max = CODE_MIN;
    acc_count = '0;
    acc_rails = '0;
  endfunction

  function automatic void reset_model();
    regs.auto_enable = 1'b1;
    regs.manual_range = RANGE_10V;
    regs.rail_low_code = 12'd128;
    regs.rail_high_code = 12'd3967;
    regs.rail_hit_percent = 7'd2;
    regs.down_peak_from_top = 12'd650;
    regs.down_peak_from_mid = 12'd300;
    clear_stats();
    cur_range = RANGE_10V;
    over_cnt = '0;
    under_cnt = '0;
  endfunction

  function automatic bit set_range(logic [1:0] r);
    if (r > RANGE_10V || r == cur_range) return 1'b0;
    cur_range = r;
    over_cnt = '0;
    under_cnt = '0;
    return 1'b1;
  endfunction

  function automatic void apply_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] d);
    case (idx)
      REG_AUTO_ENABLE: begin
        regs.auto_enable = d[0];
        over_cnt = '0;
        under_cnt = '0;
        if (!d[0]) void'(set_range(regs.manual_range));
      end
      REG_MANUAL_RANGE: begin
        regs.manual_range = d[1:0];
        if (!regs.auto_enable) void'(set_range(d[1:0]));
      end
      REG_RAIL_LOW:      regs.rail_low_code = d;
      REG_RAIL_HIGH:     regs.rail_high_code = d;
      REG_RAIL_PERCENT:  regs.rail_hit_percent = d[PCT_W-1:0];
      REG_DOWN_FROM_TOP: regs.down_peak_from_top = d;
      REG_DOWN_FROM_MID: regs.down_peak_from_mid = d;
      default: ;
    endcase
  endfunction

  function automatic void track_sample(in_item_t b);
    logic [CODE_W-1:0] code;
    int unsigned lim, lo_pk, hi_pk, pk, mid;
    bit over, sw, under;
    out_item_t r;
    code = b.sample_word[27:16];
    mid = MIDSCALE;
    sw = 1'b0;
    if (code < acc_min) acc_min = code;
    if (code > acc_max) acc_max = code;
    if (acc_count < MAX_BLOCK_LEN_DEF) acc_count++;
    if ((code <= regs.rail_low_code || code >= regs.rail_high_code) &&
        acc_rails < MAX_BLOCK_LEN_DEF)
      acc_rails++;
    if (!b.last) return;
    lim = (32'(acc_count) * 32'(regs.rail_hit_percent) + 32'd99) / 32'd100;
    if (lim == 0) lim = 1;
    lo_pk = (acc_min < mid) ? mid - acc_min : 0;
    hi_pk = (acc_max > mid) ? acc_max - mid : 0;
    pk = (lo_pk > hi_pk) ? lo_pk : hi_pk;
    over = 32'(acc_rails) >= lim;
    if (regs.auto_enable) begin
      if (over) begin
        under_cnt = '0;
        if (over_cnt < CONFIRM_MAX) over_cnt++;
        if (over_cnt >= OVER_CONFIRM_BLOCKS_DEF && cur_range < RANGE_10V)
          sw = set_range(cur_range + 2'd1);
      end else begin
        over_cnt = '0;
        under = (cur_range == RANGE_10V && pk < regs.down_peak_from_top) ||
                (cur_range == RANGE_3V3 && pk < regs.down_peak_from_mid);
        if (under) begin
          if (under_cnt < CONFIRM_MAX) under_cnt++;
          if (under_cnt >= UNDER_CONFIRM_BLOCKS_DEF) sw = set_range(cur_range - 2'd1);
        end else begin
          under_cnt = '0;
        end
      end
    end
    r.switched = sw;
    r.range_now = cur_range;
    r.peak_dist = pk[CODE_W-1:0];
    r.overrange_seen = over;
    report_q.push_back(r);
    clear_stats();
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) track_sample(in_data);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (beat_q.size() != 0) begin
          in_data <= beat_q.pop_front();
          in_valid <= 1'b1;
          gap_left = no_gaps ? 0 : $urandom_range(0, 6);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (report_q.size() == 0) begin
          flag_mismatch($sformatf("result beat with nothing expected: %p", out_data));
        end else begin
          want = report_q.pop_front();
          if (out_data.switched !== want.switched)
            flag_mismatch($sformatf("switched %0b, want %0b", out_data.switched,
                                    want.switched));
          if (out_data.range_now !== want.range_now)
            flag_mismatch($sformatf("range_now %0d, want %0d", out_data.range_now,
                                    want.range_now));
          if (out_data.peak_dist !== want.peak_dist)
            flag_mismatch($sformatf("peak_dist %0d, want %0d", out_data.peak_dist,
                                    want.peak_dist));
          if (out_data.overrange_seen !== want.overrange_seen)
            flag_mismatch($sformatf("overrange_seen %0b, want %0b",
                                    out_data.overrange_seen, want.overrange_seen));
        end
        stall_left = no_gaps ? 0 : $urandom_range(0, 6);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic wait_drained();
    do @(negedge clk); while (beat_q.size() != 0 || in_valid || report_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] d);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    apply_reg(idx, d);
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic void push_beat(logic [CODE_W-1:0] code, bit last);
    in_item_t b;
    b.sample_word = $urandom;
    b.sample_word[27:16] = code;
    b.last = last;
    beat_q.push_back(b);
    n_pushed++;
  endfunction

  function automatic logic [CODE_W-1:0] pick_code(tone_t tone);
    case (tone)
      TONE_QUIET: return 12'(2048 + $urandom_range(0, 400) - 200);
      TONE_LOUD: begin
        case ($urandom_range(0, 2))
          0: return 12'($urandom_range(0, 200));
          1: return 12'($urandom_range(3895, 4095));
          default: return 12'($urandom_range(0, 4095));
        endcase
      end
      TONE_ANY: return 12'($urandom_range(0, 4095));
      default: begin
        case ($urandom_range(0, 7))
          0: return regs.rail_low_code;
          1: return regs.rail_low_code + 12'd1;
          2: return regs.rail_high_code;
          3: return regs.rail_high_code - 12'd1;
          4: return MIDSCALE + regs.down_peak_from_top;
          5: return MIDSCALE - regs.down_peak_from_top + 12'd1;
          6: return MIDSCALE + regs.down_peak_from_mid - 12'd1;
          default: return MIDSCALE - regs.down_peak_from_mid;
        endcase
      end
    endcase
  endfunction

  function automatic void push_block(int len, tone_t tone);
    for (int i = 0; i < len; i++) push_beat(pick_code(tone), i == len - 1);
  endfunction

  function automatic logic [CFG_W-1:0] pick_value(logic [IDX_W-1:0] idx);
    logic [CFG_W-1:0] v;
    v = 12'($urandom);
    case (idx)
      REG_AUTO_ENABLE:  v[0] = ($urandom_range(0, 3) != 0);
      REG_MANUAL_RANGE: v[1:0] = 2'($urandom_range(0, 3));
      REG_RAIL_LOW: begin
        case ($urandom_range(0, 7))
          0: v = CODE_MIN;
          1: v = CODE_MAX;
          default: v = 12'($urandom_range(0, 300));
        endcase
      end
      REG_RAIL_HIGH: begin
        case ($urandom_range(0, 7))
          0: v = CODE_MAX;
          1: v = CODE_MIN;
          default: v = 12'($urandom_range(3800, 4095));
        endcase
      end
      REG_RAIL_PERCENT: begin
        case ($urandom_range(0, 7))
          0: v[6:0] = 7'd0;
          1: v[6:0] = PCT_SCALE;
          2: v[6:0] = 7'd127;
          default: v[6:0] = 7'($urandom_range(0, 20));
        endcase
      end
      REG_DOWN_FROM_TOP, REG_DOWN_FROM_MID: begin
        case ($urandom_range(0, 7))
          0: v = CODE_MIN;
          1: v = MIDSCALE;
          2: v = CODE_MAX;
          default: v = 12'($urandom_range(0, 2048));
        endcase
      end
      default: ;
    endcase
    return v;
  endfunction

  task automatic shuffle_config(bit write_all);
    logic [IDX_W-1:0] order[8];
    logic [IDX_W-1:0] tmp;
    int j;
    for (int i = 0; i < 8; i++) order[i] = IDX_W'(i);
    for (int i = 7; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < 8; i++)
      if (write_all || $urandom_range(0, 2) != 0) write_reg(order[i], pick_value(order[i]));
    end_writes();
  endtask

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int len;
    reset_model();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: walk down, up, top and bottom limits, threshold borders
    push_beat(MIDSCALE, 1'b1);
    push_beat(12'd2347, 1'b1);
    push_beat(MIDSCALE, 1'b1);
    push_beat(CODE_MIN, 1'b1);
    push_beat(CODE_MAX, 1'b1);
    push_beat(CODE_MAX, 1'b1);
    push_beat(12'd1398, 1'b1);
    push_beat(12'd2697, 1'b1);
    push_beat(12'd128, 1'b0);
    push_beat(MIDSCALE, 1'b0);
    push_beat(MIDSCALE, 1'b1);
    push_beat(12'd129, 1'b0);
    push_beat(12'd3966, 1'b1);
    wait_drained();

    // manual mode: immediate apply, invalid range held off, back to auto
    write_reg(REG_AUTO_ENABLE, 12'd0);
    write_reg(REG_MANUAL_RANGE, {10'd0, RANGE_0V3});
    end_writes();
    push_beat(CODE_MIN, 1'b1);
    wait_drained();
    write_reg(REG_MANUAL_RANGE, {10'h3FF, RANGE_INVALID});
    end_writes();
    push_beat(MIDSCALE, 1'b1);
    wait_drained();
    write_reg(REG_AUTO_ENABLE, 12'hFFF);
    write_reg(REG_UNUSED, 12'hFFF);
    end_writes();
    push_beat(CODE_MAX, 1'b1);
    push_beat(CODE_MAX, 1'b1);
    wait_drained();

    // all-rail block at percent 100: limit equals the count
    write_reg(REG_RAIL_PERCENT, {5'd0, PCT_SCALE});
    end_writes();
    no_gaps = 1'b1;
    for (int i = 0; i < RAIL_BLOCK; i++) push_beat(CODE_MIN, i == RAIL_BLOCK - 1);
    wait_drained();

    // random phases; the drain before each phase holds the sender off
    n_pushed = 0;
    shuffle_config(1'b1);
    while (n_pushed < RANDOM_BEATS) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(3, 10)) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 12);
        push_block(len, tone_t'($urandom_range(0, 3)));
      end
      wait_drained();
      shuffle_config(1'b0);
    end

    wait_drained();
    if (report_q.size() != 0) flag_mismatch("expected results left over");
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
